/* hw/rtl/thumb_load_request_sequencer_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Thumb load request sequencer.
// Each macro expands to one labeled concurrent assertion on the block clock.
// ----------------------------------------------------------------------------
`ifndef THUMB_LOAD_REQUEST_SEQUENCER_TOP_DEFINES_SVH
`define THUMB_LOAD_REQUEST_SEQUENCER_TOP_DEFINES_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define TLRS_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define TLRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tlrs_pkg.sv */
// ----------------------------------------------------------------------------
// Thumb load request sequencer package
// Types and constants shared by the sequencer and its checker.
// ----------------------------------------------------------------------------
package tlrs_pkg;

  localparam int unsigned AddrW   = 32;
  localparam int unsigned OpW     = 3;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned ListW   = 8;
  localparam int unsigned BytesW  = 3;
  localparam int unsigned KindW   = 2;

  localparam logic [BytesW-1:0] WordBytes = 3'd4;
  localparam logic [BytesW-1:0] HalfBytes = 3'd2;
  localparam logic [BytesW-1:0] ByteBytes = 3'd1;
  localparam logic [AddrW-1:0]  AddrStep  = 32'd4;

  typedef enum logic [OpW-1:0] {
    OP_LDR   = 3'd0,
    OP_LDRH  = 3'd1,
    OP_LDRB  = 3'd2,
    OP_LDRSB = 3'd3,
    OP_LDRSH = 3'd4,
    OP_LDM   = 3'd5
  } opcode_e;

  typedef enum logic [KindW-1:0] {
    KIND_READ      = 2'd0,
    KIND_WRITEBACK = 2'd1,
    KIND_SKIP      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LIST,
    ST_WRITEBACK
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [AddrW-1:0]   read_address;
    logic [BytesW-1:0]  read_bytes;
    logic               sign_extend;
    logic [RegIdxW-1:0] target;
    logic [AddrW-1:0]   new_base;
    logic               last;
  } result_t;

endpackage

/* hw/rtl/thumb_load_request_sequencer_top.sv */
// ----------------------------------------------------------------------------
// Thumb load request sequencer
// A single load or skip is registered and valid in the cycle after acceptance, one per
// cycle while the output is not stalled. An LDM first enters the list state, which then
// registers one result per cycle while not stalled. Reset clears state and valid.
// ----------------------------------------------------------------------------
module thumb_load_request_sequencer_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tlrs_pkg::OpW-1:0]      opcode_i,
  input  logic [tlrs_pkg::AddrW-1:0]    base_value_i,
  input  logic [tlrs_pkg::AddrW-1:0]    offset_value_i,
  input  logic [tlrs_pkg::RegIdxW-1:0]  dest_index_i,
  input  logic [tlrs_pkg::RegIdxW-1:0]  base_index_i,
  input  logic [tlrs_pkg::ListW-1:0]    register_list_i,
  input  logic                          condition_passed_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tlrs_pkg::KindW-1:0]    result_kind_o,
  output logic [tlrs_pkg::AddrW-1:0]    read_address_o,
  output logic [tlrs_pkg::BytesW-1:0]   read_bytes_o,
  output logic                          sign_extend_o,
  output logic [tlrs_pkg::RegIdxW-1:0]  target_register_o,
  output logic [tlrs_pkg::AddrW-1:0]    new_base_value_o,
  output logic                          last_o
);

  tlrs_pkg::state_e  state_q, state_d;
  logic              out_valid_q, out_valid_d;
  tlrs_pkg::result_t res_q, res_d;

  logic [tlrs_pkg::ListW-1:0]   list_q, list_d;
  logic [tlrs_pkg::AddrW-1:0]   addr_q, addr_d;
  logic [tlrs_pkg::RegIdxW-1:0] bidx_q, bidx_d;
  logic                         wb_q, wb_d;

  logic                         out_free;
  logic                         single_load;
  logic [tlrs_pkg::AddrW-1:0]   add_a, add_b, add_sum;
  logic [tlrs_pkg::ListW-1:0]   list_rest;
  logic [tlrs_pkg::RegIdxW-1:0] low_idx;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign single_load = opcode_i inside {tlrs_pkg::OP_LDR, tlrs_pkg::OP_LDRH,
                                        tlrs_pkg::OP_LDRB, tlrs_pkg::OP_LDRSB,
                                        tlrs_pkg::OP_LDRSH};

  // The one adder forms the single-load address, then steps the LDM address.
  assign add_a   = (state_q == tlrs_pkg::ST_IDLE) ? base_value_i : addr_q;
  assign add_b   = (state_q == tlrs_pkg::ST_IDLE) ? offset_value_i : tlrs_pkg::AddrStep;
  assign add_sum = add_a + add_b;

  assign list_rest = list_q & (list_q - tlrs_pkg::ListW'(1));

  always_comb begin
    low_idx = '0;
    for (int i = tlrs_pkg::ListW - 1; i >= 0; i--) begin
      if (list_q[i]) begin
        low_idx = tlrs_pkg::RegIdxW'(i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    list_d      = list_q;
    addr_d      = addr_q;
    bidx_d      = bidx_q;
    wb_d        = wb_q;
    in_stall_o  = 1'b1;

    case (state_q)
      tlrs_pkg::ST_IDLE: begin
        in_stall_o = !out_free;
        if (in_valid_i && out_free) begin
          out_valid_d = 1'b1;
          res_d       = '0;
          res_d.kind  = tlrs_pkg::KIND_SKIP;
          res_d.last  = 1'b1;
          if (condition_passed_i && single_load) begin
            res_d.kind         = tlrs_pkg::KIND_READ;
            res_d.read_address = add_sum;
            res_d.target       = dest_index_i;
            case (opcode_i)
              tlrs_pkg::OP_LDRH: begin
                res_d.read_bytes = tlrs_pkg::HalfBytes;
              end
              tlrs_pkg::OP_LDRB: begin
                res_d.read_bytes = tlrs_pkg::ByteBytes;
              end
              tlrs_pkg::OP_LDRSB: begin
                res_d.read_bytes  = tlrs_pkg::ByteBytes;
                res_d.sign_extend = 1'b1;
              end
              tlrs_pkg::OP_LDRSH: begin
                res_d.read_bytes  = tlrs_pkg::HalfBytes;
                res_d.sign_extend = 1'b1;
              end
              default: begin
                res_d.read_bytes = tlrs_pkg::WordBytes;
              end
            endcase
          end else if (condition_passed_i && opcode_i == tlrs_pkg::OP_LDM
                       && register_list_i != '0) begin
            out_valid_d = 1'b0;
            res_d       = res_q;
            list_d      = register_list_i;
            addr_d      = base_value_i;
            bidx_d      = base_index_i;
            wb_d        = !register_list_i[base_index_i];
            state_d     = tlrs_pkg::ST_LIST;
          end
        end
      end
      tlrs_pkg::ST_LIST: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          res_d              = '0;
          res_d.kind         = tlrs_pkg::KIND_READ;
          res_d.read_address = addr_q;
          res_d.read_bytes   = tlrs_pkg::WordBytes;
          res_d.target       = low_idx;
          res_d.last         = (list_rest == '0) && !wb_q;
          addr_d             = add_sum;
          list_d             = list_rest;
          if (list_rest == '0) begin
            state_d = wb_q ? tlrs_pkg::ST_WRITEBACK : tlrs_pkg::ST_IDLE;
          end
        end
      end
      tlrs_pkg::ST_WRITEBACK: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          res_d          = '0;
          res_d.kind     = tlrs_pkg::KIND_WRITEBACK;
          res_d.target   = bidx_q;
          res_d.new_base = addr_q;
          res_d.last     = 1'b1;
          state_d        = tlrs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tlrs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlrs_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    list_q <= list_d;
    addr_q <= addr_d;
    bidx_q <= bidx_d;
    wb_q   <= wb_d;
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = res_q.kind;
  assign read_address_o    = res_q.read_address;
  assign read_bytes_o      = res_q.read_bytes;
  assign sign_extend_o     = res_q.sign_extend;
  assign target_register_o = res_q.target;
  assign new_base_value_o  = res_q.new_base;
  assign last_o            = res_q.last;

endmodule

/* hw/rtl/tlrs_checker.sv */
// ----------------------------------------------------------------------------
// Thumb load request sequencer checker
// Port-level assertions on results, bound to the top level.
// ----------------------------------------------------------------------------
`include "thumb_load_request_sequencer_top_defines.svh"

module tlrs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic [tlrs_pkg::KindW-1:0]    result_kind_o,
  input logic [tlrs_pkg::AddrW-1:0]    read_address_o,
  input logic [tlrs_pkg::BytesW-1:0]   read_bytes_o,
  input logic                          sign_extend_o,
  input logic [tlrs_pkg::RegIdxW-1:0]  target_register_o,
  input logic [tlrs_pkg::AddrW-1:0]    new_base_value_o,
  input logic                          last_o
);

  `TLRS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(result_kind_o) && $stable(read_address_o)
    && $stable(target_register_o) && $stable(new_base_value_o) && $stable(last_o),
    "Stalled result transaction changed.")

  `TLRS_ASSERT_SAME(a_skip_last, clk_i, rst_ni,
    out_valid_o && result_kind_o == tlrs_pkg::KIND_SKIP,
    last_o && read_bytes_o == '0 && new_base_value_o == '0,
    "Skipped result is not a lone final result.")

  `TLRS_ASSERT_SAME(a_wb_last, clk_i, rst_ni,
    out_valid_o && result_kind_o == tlrs_pkg::KIND_WRITEBACK,
    last_o && read_bytes_o == '0 && !sign_extend_o && read_address_o == '0,
    "Writeback result is malformed.")

  `TLRS_ASSERT_SAME(a_read_size, clk_i, rst_ni,
    out_valid_o && result_kind_o == tlrs_pkg::KIND_READ,
    (read_bytes_o == tlrs_pkg::WordBytes || read_bytes_o == tlrs_pkg::HalfBytes
     || read_bytes_o == tlrs_pkg::ByteBytes) && new_base_value_o == '0,
    "Read result has an invalid size.")

endmodule

bind thumb_load_request_sequencer_top tlrs_checker u_tlrs_checker (.*);
